@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the frame masker rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

@@ rtl/core/wscfm_pkg.sv @@
// types, constants and helpers for the websocket client frame masker
// no dependencies; imported by every module of the block
`default_nettype none

package wscfm_pkg;

   localparam int unsigned PLEN_W = 32;

   // job queue between front and back end
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // websocket opcodes
   localparam logic [3:0] OP_TEXT   = 4'd1;
   localparam logic [3:0] OP_BINARY = 4'd2;
   localparam logic [3:0] OP_CLOSE  = 4'd8;
   localparam logic [3:0] OP_PING   = 4'd9;
   localparam logic [3:0] OP_PONG   = 4'd10;

   // length encoding limits and marker bytes
   localparam logic [PLEN_W-1:0] LEN7_MAX  = 32'd125;
   localparam logic [PLEN_W-1:0] LEN16_MAX = 32'd65535;
   localparam logic [7:0] FIN_BIT    = 8'h80;
   localparam logic [7:0] MASK_BIT   = 8'h80;
   localparam logic [7:0] LEN16_CODE = 8'hfe;
   localparam logic [7:0] LEN64_CODE = 8'hff;

   // header sizes in bytes
   localparam logic [3:0] HDR_SHORT_BYTES = 4'd6;
   localparam logic [3:0] HDR_MID_BYTES   = 4'd8;
   localparam logic [3:0] HDR_LONG_BYTES  = 4'd14;
   localparam logic [3:0] KEY_BYTES       = 4'd4;

   localparam logic [31:0] MAX_FRAME_RESET = 32'd648;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_BUSY    = 2'd2,
      ST_LIMIT   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      HK_SHORT = 2'd0,
      HK_MID   = 2'd1,
      HK_LONG  = 2'd2
   } hdr_kind_type;

   // one unit of work for the back end: a ready-made word or a whole header
   typedef struct packed {
      logic              is_hdr;
      logic [7:0]        out_val;
      logic              last;
      status_type        status;
      logic [3:0]        opcode;
      hdr_kind_type      kind;
      logic [PLEN_W-1:0] plen;
      logic [31:0]       key;
   } job_type;

   // mask byte by index, index 0 is the first wire byte
   function automatic logic [7:0] mask_byte(input logic [31:0] key, input logic [1:0] idx);
      logic [1:0] sel;
      sel = 2'd3 - idx;
      return key[{sel, 3'b000} +: 8];
   endfunction

   // total header length for a length encoding
   function automatic logic [3:0] hdr_len(input hdr_kind_type kind);
      logic [3:0] n;
      case (kind)
         HK_SHORT: n = HDR_SHORT_BYTES;
         HK_MID:   n = HDR_MID_BYTES;
         default:  n = HDR_LONG_BYTES;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/wscfm_front.sv @@
// front end: accepts requests, checks starts, tracks the open frame, masks payload
// depends on wscfm_pkg; feeds jobs into wscfm_queue
`default_nettype none

module wscfm_front
   import wscfm_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // configuration
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [31:0]       csr_max_frame_bytes,
   // requests
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_cmd,
   input  wire logic [3:0]        req_opcode,
   input  wire logic [PLEN_W-1:0] req_payload_length,
   input  wire logic [31:0]       req_mask_key,
   input  wire logic [7:0]        req_data_byte,
   // job queue
   input  wire logic              q_full,
   output logic                   q_push,
   output job_type                q_job
);

   logic [31:0]       max_frame_ff, max_frame_in;
   logic [PLEN_W-1:0] bytes_left_ff, bytes_left_in;
   logic [31:0]       held_mask_ff, held_mask_in;
   logic [1:0]        mask_phase_ff, mask_phase_in;

   logic              accept;
   logic              op_ok, op_ctrl, frame_open, too_long, over_cap;
   logic [3:0]        hdr_bytes;
   hdr_kind_type      kind;
   logic [PLEN_W:0]   frame_total;

   assign csr_ready = 1'b1;
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // length beyond the configured length field width
   generate
      if (LENGTH_BITS < PLEN_W) begin : g_len_chk
         assign too_long = |req_payload_length[PLEN_W-1:LENGTH_BITS];
      end else begin : g_len_free
         assign too_long = 1'b0;
      end
   endgenerate

   // classify the start request
   always_comb begin
      op_ok = (req_opcode == OP_TEXT) || (req_opcode == OP_BINARY) ||
              (req_opcode == OP_CLOSE) || (req_opcode == OP_PING) ||
              (req_opcode == OP_PONG);
      op_ctrl = (req_opcode == OP_CLOSE) || (req_opcode == OP_PING) ||
                (req_opcode == OP_PONG);
      frame_open = (bytes_left_ff != '0);
      if (req_payload_length <= LEN7_MAX) begin
         kind = HK_SHORT;
      end else if (req_payload_length <= LEN16_MAX) begin
         kind = HK_MID;
      end else begin
         kind = HK_LONG;
      end
      hdr_bytes   = hdr_len(kind);
      frame_total = {1'b0, req_payload_length} + (PLEN_W+1)'(hdr_bytes);
      over_cap    = frame_total > (PLEN_W+1)'(max_frame_ff);
   end

   // job build and frame state update
   always_comb begin
      max_frame_in  = max_frame_ff;
      bytes_left_in = bytes_left_ff;
      held_mask_in  = held_mask_ff;
      mask_phase_in = mask_phase_ff;
      q_push        = 1'b0;
      q_job.is_hdr  = 1'b0;
      q_job.out_val = '0;
      q_job.last    = 1'b1;
      q_job.status  = ST_OK;
      q_job.opcode  = req_opcode;
      q_job.kind    = kind;
      q_job.plen    = req_payload_length;
      q_job.key     = req_mask_key;

      if (csr_valid && csr_ready) begin
         max_frame_in = csr_max_frame_bytes;
      end

      if (accept) begin
         q_push = 1'b1;
         if (req_cmd) begin
            if (!frame_open) begin
               q_job.status = ST_INVALID;
            end else begin
               q_job.out_val = req_data_byte ^ mask_byte(held_mask_ff, mask_phase_ff);
               q_job.last    = (bytes_left_ff == PLEN_W'(1));
               bytes_left_in = bytes_left_ff - PLEN_W'(1);
               mask_phase_in = mask_phase_ff + 2'd1;
            end
         end else if (!op_ok || (op_ctrl && (req_payload_length > LEN7_MAX))) begin
            q_job.status = ST_INVALID;
         end else if (frame_open) begin
            q_job.status = ST_BUSY;
         end else if (too_long || over_cap) begin
            q_job.status = ST_LIMIT;
         end else begin
            q_job.is_hdr  = 1'b1;
            q_job.last    = 1'b0;
            bytes_left_in = req_payload_length;
            held_mask_in  = req_mask_key;
            mask_phase_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff  <= MAX_FRAME_RESET;
         bytes_left_ff <= '0;
         held_mask_ff  <= '0;
         mask_phase_ff <= '0;
      end else begin
         max_frame_ff  <= max_frame_in;
         bytes_left_ff <= bytes_left_in;
         held_mask_ff  <= held_mask_in;
         mask_phase_ff <= mask_phase_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/wscfm_queue.sv @@
// short job queue that decouples the front end from the serialiser
// depends on wscfm_pkg; head word is visible while the queue is not empty
`default_nettype none

module wscfm_queue
   import wscfm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output job_type      head_job,
   output logic         empty,
   output logic         full
);

   job_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_job = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/wscfm_back.sv @@
// back end: walks jobs out as wire words, one per cycle while rsp_ready allows, through an output register
// depends on wscfm_pkg and assert_macros.svh; reads the head of wscfm_queue
`default_nettype none
`include "assert_macros.svh"

module wscfm_back
   import wscfm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   // job queue
   input  wire logic    q_empty,
   input  wire job_type q_head,
   output logic         q_pop,
   // results
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_last,
   output logic [1:0]   rsp_status
);

   logic [3:0]   idx_ff, idx_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   out_byte_ff, out_byte_in;
   logic         last_ff, last_in;
   status_type   status_ff, status_in;

   logic         can_load;
   logic [3:0]   hl, last_idx, key_start;
   logic [7:0]   hdr_byte;
   logic [63:0]  len64;
   logic [3:0]   len_pos;
   logic [2:0]   len_sel;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last     = last_ff;
   assign rsp_status   = status_ff;

   // header word at the current position
   always_comb begin
      hl        = hdr_len(q_head.kind);
      last_idx  = hl - 4'd1;
      key_start = hl - KEY_BYTES;
      len64     = {{(64-PLEN_W){1'b0}}, q_head.plen};
      len_pos   = 4'd9 - idx_ff;
      len_sel   = len_pos[2:0];
      if (idx_ff >= key_start) begin
         hdr_byte = mask_byte(q_head.key, 2'(idx_ff - key_start));
      end else if (idx_ff == 4'd0) begin
         hdr_byte = FIN_BIT | {4'b0000, q_head.opcode};
      end else begin
         case (q_head.kind)
            HK_SHORT: hdr_byte = MASK_BIT | {1'b0, q_head.plen[6:0]};
            HK_MID: begin
               case (idx_ff)
                  4'd1:    hdr_byte = LEN16_CODE;
                  4'd2:    hdr_byte = q_head.plen[15:8];
                  default: hdr_byte = q_head.plen[7:0];
               endcase
            end
            default: begin
               if (idx_ff == 4'd1) begin
                  hdr_byte = LEN64_CODE;
               end else begin
                  hdr_byte = len64[{len_sel, 3'b000} +: 8];
               end
            end
         endcase
      end
   end

   // output register load and job sequencing
   always_comb begin
      can_load     = !rsp_valid_ff || rsp_ready;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      out_byte_in  = out_byte_ff;
      last_in      = last_ff;
      status_in    = status_ff;
      q_pop        = 1'b0;
      if (can_load) begin
         rsp_valid_in = !q_empty;
         if (!q_empty) begin
            if (q_head.is_hdr) begin
               out_byte_in = hdr_byte;
               last_in     = (idx_ff == last_idx) && (q_head.plen == '0);
               status_in   = ST_OK;
               if (idx_ff == last_idx) begin
                  q_pop  = 1'b1;
                  idx_in = 4'd0;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end else begin
               out_byte_in = q_head.out_val;
               last_in     = q_head.last;
               status_in   = q_head.status;
               q_pop       = 1'b1;
               idx_in      = 4'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      last_ff     <= last_in;
      status_ff   <= status_in;
   end

   // an error result is a single closing zero word
   `ASSERT_HOLDS(a_err_word, clock, reset,
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_last && (rsp_out_byte == 8'd0)))
   // header position stays inside the header, and idle for single-word jobs
   `ASSERT_HOLDS(a_idx_range, clock, reset,
      !q_empty |-> (q_head.is_hdr ? (idx_ff < hl) : (idx_ff == 4'd0)))
   // never pops an empty queue
   `ASSERT_NEVER(a_pop_empty, clock, reset, q_pop && q_empty)

endmodule

`default_nettype wire

@@ rtl/core/websocket_client_frame_masker.sv @@
// top level of the websocket client frame masker
// depends on wscfm_pkg, wscfm_front, wscfm_queue and wscfm_back
`default_nettype none

// Builds masked client frames as a byte stream. The front end takes one request
// per cycle while its four-job queue has room: starts are checked and refused
// starts and stray payload bytes become a single error word; payload bytes are
// masked on the way in. The back end emits one word per cycle, while rsp_ready
// allows, behind an output register: a payload byte or a refused item is one
// word, an accepted start a header of 6, 8 or 14 words (short, 16-bit or 64-bit
// length). Requests keep being accepted while a header is still going out,
// until the queue fills. max_frame_bytes is written on the csr port, always
// ready; write it only while the block is idle.

module websocket_client_frame_masker
   import wscfm_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // configuration
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [31:0]       csr_max_frame_bytes,
   // requests
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_cmd,
   input  wire logic [3:0]        req_opcode,
   input  wire logic [PLEN_W-1:0] req_payload_length,
   input  wire logic [31:0]       req_mask_key,
   input  wire logic [7:0]        req_data_byte,
   // results
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_last,
   output logic [1:0]             rsp_status
);

   logic    q_push, q_pop, q_empty, q_full;
   job_type q_job, q_head;

   wscfm_front #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_max_frame_bytes (csr_max_frame_bytes),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_opcode          (req_opcode),
      .req_payload_length  (req_payload_length),
      .req_mask_key        (req_mask_key),
      .req_data_byte       (req_data_byte),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_job               (q_job)
   );

   wscfm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .pop      (q_pop),
      .head_job (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   wscfm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .rsp_status   (rsp_status)
   );

endmodule

`default_nettype wire
